// ===== hw/rtl/pcom_pkg.sv =====
// Shared types, codes and constants of the point catalog offset matcher.
// Used by every RTL module of the block but pcom_ram, and by its checker; depends on nothing.
`default_nettype none

package pcom_pkg;

    // Defaults for the top-level parameters.
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int FRAC_BITS_DEF   = 4;

    // Match radius in whole pixels.
    localparam int MATCH_LIMIT = 3;

    // Entries in the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Field widths.
    localparam int POS_W      = 19;
    localparam int SHIFT_W    = 20;
    localparam int SUM_W      = 21;
    localparam int SIZE_W     = 15;
    localparam int INDEX_W    = 10;
    localparam int OFFSET_W   = 20;
    localparam int DIST_W     = 12;
    localparam int MATCH_W    = 16;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Item mode codes.
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_QUERY = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_SHIFT_X      = 2'd0;
    localparam logic [1:0] REG_SHIFT_Y      = 2'd1;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd2;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd3;

    // Reset value of both image size registers.
    localparam logic [SIZE_W-1:0] IMAGE_SIZE_RESET = 15'd2048;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
    } pcom_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0]         entry_index;
        logic signed [OFFSET_W-1:0] offset_x;
        logic signed [OFFSET_W-1:0] offset_y;
        logic [DIST_W-1:0]          dist_squared;
        logic [MATCH_W-1:0]         match_number;
    } pcom_result_t;

    typedef struct packed {
        logic signed [SHIFT_W-1:0] shift_x;
        logic signed [SHIFT_W-1:0] shift_y;
        logic [SIZE_W-1:0]         image_width;
        logic [SIZE_W-1:0]         image_height;
    } pcom_cfg_t;

    // One classified command from the front to the back.
    typedef struct packed {
        cmd_kind_t               kind;
        logic [POS_W-1:0]        pos_x;
        logic [POS_W-1:0]        pos_y;
        logic signed [SUM_W-1:0] sum_x;
        logic signed [SUM_W-1:0] sum_y;
    } pcom_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pcom_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; used for the reference point table.
`default_nettype none

module pcom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pcom_front.sv =====
// Front part: accepts items, applies the shift, runs the bounds test and
// drops items that need no work. Depends on pcom_pkg.
`default_nettype none

module pcom_front
    import pcom_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  pcom_cfg_t  cfg,
    input  logic       item_valid,
    output logic       item_ready,
    input  pcom_item_t item,
    output logic       cmd_valid,
    input  logic       cmd_ready,
    output pcom_cmd_t  cmd
);

    // Wide enough for the shifted point and for (size - 1) scaled up.
    localparam int BW = ((SIZE_W + 1 + FRAC_BITS > SUM_W) ? SIZE_W + 1 + FRAC_BITS : SUM_W) + 1;
    localparam logic signed [BW-1:0] LOW_BOUND = BW'(1 << FRAC_BITS);

    logic                    st_valid_reg;
    logic                    st_valid_next;
    pcom_cmd_t               st_cmd_reg;
    pcom_cmd_t               cmd_next;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic signed [BW-1:0]    high_x;
    logic signed [BW-1:0]    high_y;
    logic                    inside_xy;
    logic                    keep;
    logic                    accept;

    always_comb
    begin
        sum_x = SUM_W'($signed({2'b00, item.pos_x})) + SUM_W'(cfg.shift_x);
        sum_y = SUM_W'($signed({2'b00, item.pos_y})) + SUM_W'(cfg.shift_y);
        high_x = (BW'($signed({1'b0, cfg.image_width})) - BW'(1)) <<< FRAC_BITS;
        high_y = (BW'($signed({1'b0, cfg.image_height})) - BW'(1)) <<< FRAC_BITS;
        inside_xy = (BW'(sum_x) >= LOW_BOUND) && (BW'(sum_x) <= high_x) &&
                    (BW'(sum_y) >= LOW_BOUND) && (BW'(sum_y) <= high_y);

        cmd_next.pos_x = item.pos_x;
        cmd_next.pos_y = item.pos_y;
        cmd_next.sum_x = sum_x;
        cmd_next.sum_y = sum_y;
        unique case (item.mode)
            MODE_LOAD:
            begin
                cmd_next.kind = CMD_LOAD;
                keep = 1'b1;
            end
            MODE_QUERY:
            begin
                cmd_next.kind = CMD_QUERY;
                keep = inside_xy;
            end
            MODE_CLEAR:
            begin
                cmd_next.kind = CMD_CLEAR;
                keep = 1'b1;
            end
            default:
            begin
                cmd_next.kind = CMD_CLEAR;
                keep = 1'b0;
            end
        endcase
    end

    assign item_ready = !st_valid_reg || cmd_ready;
    assign accept     = item_valid && item_ready;
    assign cmd_valid  = st_valid_reg;
    assign cmd        = st_cmd_reg;

    always_comb
    begin
        st_valid_next = st_valid_reg;
        if (accept)
        begin
            st_valid_next = keep;
        end
        else if (cmd_ready)
        begin
            st_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
        end
        else
        begin
            st_valid_reg <= st_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_cmd_reg <= cmd_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pcom_queue.sv =====
// Short command queue between the front and the back.
// Depends on pcom_pkg for the command type.
`default_nettype none

module pcom_queue
    import pcom_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  pcom_cmd_t push_cmd,
    output logic      pop_valid,
    input  logic      pop_ready,
    output pcom_cmd_t pop_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pcom_cmd_t        entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (fill_reg != CNT_W'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = entries[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pcom_back.sv =====
// Back part: owns the reference table, the entry count and the match count,
// scans the table for queries and holds the result register.
// Depends on pcom_pkg and pcom_ram.
`default_nettype none

module pcom_back
    import pcom_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cmd_valid,
    output logic         cmd_ready,
    input  pcom_cmd_t    cmd,
    output logic         result_valid,
    input  logic         result_ready,
    output pcom_result_t result
);

    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int IW   = (AW > INDEX_W) ? AW : INDEX_W;
    localparam int LIM  = MATCH_LIMIT << FRAC_BITS;
    localparam int LIM2 = LIM * LIM;
    // A difference that can still match fits in NW signed bits.
    localparam int NW   = $clog2(LIM) + 1;
    localparam int DW   = (2 * NW + 1 > DIST_W) ? 2 * NW + 1 : DIST_W;
    localparam int DXW  = SUM_W + 1;
    localparam logic signed [DXW-1:0] LIM_S  = DXW'(LIM);
    localparam logic [DW-1:0]         LIM2_D = DW'(LIM2);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } back_state_t;

    back_state_t  state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [MATCH_W-1:0] match_reg, match_next;
    logic [CW-1:0] issue_reg, issue_next;
    logic          result_valid_reg, result_valid_next;
    pcom_result_t  result_reg;
    pcom_cmd_t     query_reg;

    // Read pipeline: p1 = read in flight, p2 = differences, p3 = distance.
    logic          p1_valid_reg, p1_valid_next;
    logic [AW-1:0] p1_idx_reg;
    logic          p2_valid_reg, p2_valid_next;
    logic [AW-1:0] p2_idx_reg;
    logic          p2_near_reg;
    logic signed [NW-1:0] p2_dx_reg;
    logic signed [NW-1:0] p2_dy_reg;
    logic signed [OFFSET_W-1:0] p2_offx_reg;
    logic signed [OFFSET_W-1:0] p2_offy_reg;
    logic          p3_valid_reg, p3_valid_next;
    logic          p3_hit_reg;
    logic [AW-1:0] p3_idx_reg;
    logic [DW-1:0] p3_d2_reg;
    logic signed [OFFSET_W-1:0] p3_offx_reg;
    logic signed [OFFSET_W-1:0] p3_offy_reg;

    logic [2*POS_W-1:0] ram_rdata;
    logic [POS_W-1:0]   ref_x;
    logic [POS_W-1:0]   ref_y;
    logic               ram_we;
    logic               table_full;
    logic               take;
    logic               issue_go;
    logic               found;
    logic               drained;
    logic signed [DXW-1:0] dx;
    logic signed [DXW-1:0] dy;
    logic               near;
    logic signed [OFFSET_W-1:0] offx;
    logic signed [OFFSET_W-1:0] offy;
    logic signed [2*NW-1:0] sq_x;
    logic signed [2*NW-1:0] sq_y;
    logic [DW-1:0]      d2;
    logic               hit;
    logic [IW-1:0]      idx_wide;

    pcom_ram #(
        .WIDTH (2 * POS_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata ({cmd.pos_x, cmd.pos_y}),
        .raddr (issue_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign ref_x = ram_rdata[2*POS_W-1:POS_W];
    assign ref_y = ram_rdata[POS_W-1:0];

    // A query waits while the previous result has not been taken.
    assign cmd_ready  = (state_reg == ST_IDLE) &&
                        ((cmd.kind != CMD_QUERY) || !result_valid_reg);
    assign take       = cmd_valid && cmd_ready;
    assign table_full = (count_reg == CW'(TABLE_DEPTH));
    assign ram_we     = take && (cmd.kind == CMD_LOAD) && !table_full;

    assign issue_go = (state_reg == ST_SCAN) && (issue_reg < count_reg);
    assign found    = p3_valid_reg && p3_hit_reg;
    assign drained  = !issue_go && !p1_valid_reg && !p2_valid_reg && !p3_valid_reg;

    // Stage two: differences and the coarse window test.
    always_comb
    begin
        dx   = DXW'(query_reg.sum_x) - DXW'($signed({3'b000, ref_x}));
        dy   = DXW'(query_reg.sum_y) - DXW'($signed({3'b000, ref_y}));
        near = (dx > -LIM_S) && (dx < LIM_S) && (dy > -LIM_S) && (dy < LIM_S);
        offx = $signed({1'b0, ref_x}) - $signed({1'b0, query_reg.pos_x});
        offy = $signed({1'b0, ref_y}) - $signed({1'b0, query_reg.pos_y});
    end

    // Stage three: squared distance on the narrowed differences.
    always_comb
    begin
        sq_x = p2_dx_reg * p2_dx_reg;
        sq_y = p2_dy_reg * p2_dy_reg;
        d2   = DW'($unsigned(sq_x)) + DW'($unsigned(sq_y));
        hit  = p2_near_reg && (d2 < LIM2_D);
    end

    assign idx_wide = IW'(p3_idx_reg);

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        match_next        = match_reg;
        issue_next        = issue_reg;
        result_valid_next = result_valid_reg && !result_ready;
        p1_valid_next     = issue_go && !found;
        p2_valid_next     = p1_valid_reg && !found;
        p3_valid_next     = p2_valid_reg && !found;
        if (issue_go)
        begin
            issue_next = issue_reg + 1'b1;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    unique case (cmd.kind)
                        CMD_LOAD:
                        begin
                            if (!table_full)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = ST_SCAN;
                                issue_next = '0;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            match_next = '0;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                priority if (found)
                begin
                    state_next        = ST_IDLE;
                    result_valid_next = 1'b1;
                    if (match_reg != '1)
                    begin
                        match_next = match_reg + 1'b1;
                    end
                end
                else if (drained)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            match_reg        <= '0;
            issue_reg        <= '0;
            result_valid_reg <= 1'b0;
            p1_valid_reg     <= 1'b0;
            p2_valid_reg     <= 1'b0;
            p3_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            match_reg        <= match_next;
            issue_reg        <= issue_next;
            result_valid_reg <= result_valid_next;
            p1_valid_reg     <= p1_valid_next;
            p2_valid_reg     <= p2_valid_next;
            p3_valid_reg     <= p3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && (cmd.kind == CMD_QUERY))
        begin
            query_reg <= cmd;
        end
        p1_idx_reg  <= issue_reg[AW-1:0];
        p2_idx_reg  <= p1_idx_reg;
        p2_near_reg <= near;
        p2_dx_reg   <= dx[NW-1:0];
        p2_dy_reg   <= dy[NW-1:0];
        p2_offx_reg <= offx;
        p2_offy_reg <= offy;
        p3_idx_reg  <= p2_idx_reg;
        p3_hit_reg  <= hit;
        p3_d2_reg   <= d2;
        p3_offx_reg <= p2_offx_reg;
        p3_offy_reg <= p2_offy_reg;
        if (found)
        begin
            result_reg.entry_index  <= idx_wide[INDEX_W-1:0];
            result_reg.offset_x     <= p3_offx_reg;
            result_reg.offset_y     <= p3_offy_reg;
            result_reg.dist_squared <= p3_d2_reg[DIST_W-1:0];
            result_reg.match_number <= match_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/point_catalog_offset_match_top.sv =====
// Top level of the point catalog offset matcher: configuration registers and
// the front, queue and back. Depends on pcom_pkg, pcom_front, pcom_queue, pcom_back.
`default_nettype none

// Channel        Direction  Handshake                    Payload
// item           in         item_valid / item_ready      pcom_item_t (mode, pos_x, pos_y)
// result         out        result_valid / result_ready  pcom_result_t
// configuration  in         APB psel/penable/pwrite      paddr, pwdata, prdata
//
// A query that passes the bounds test scans the table: it is read one entry
// per cycle through the single read port of the table RAM, followed by a
// three-stage distance pipeline; the scan stops at the first match.
// Reset clears the entry count, the match count and the registers; the table
// itself is not cleared, since only loaded entries are ever read.
// The front register and the two-entry queue keep taking items until they fill up
// while the back scans or while a result waits to be taken; a query waits in the
// queue until the result register is free.

module point_catalog_offset_match_top
    import pcom_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  pcom_item_t            item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output pcom_result_t          result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    pcom_cfg_t  cfg_reg;
    logic [1:0] reg_index;
    logic       cfg_write;
    logic       front_valid;
    logic       front_ready;
    pcom_cmd_t  front_cmd;
    logic       back_valid;
    logic       back_ready;
    pcom_cmd_t  back_cmd;

    // Registers sit at word addresses, so the index is the upper address bits.
    assign reg_index = paddr[APB_ADDR_W-1:2];
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.shift_x      <= '0;
            cfg_reg.shift_y      <= '0;
            cfg_reg.image_width  <= IMAGE_SIZE_RESET;
            cfg_reg.image_height <= IMAGE_SIZE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_SHIFT_X:      cfg_reg.shift_x      <= pwdata[SHIFT_W-1:0];
                REG_SHIFT_Y:      cfg_reg.shift_y      <= pwdata[SHIFT_W-1:0];
                REG_IMAGE_WIDTH:  cfg_reg.image_width  <= pwdata[SIZE_W-1:0];
                REG_IMAGE_HEIGHT: cfg_reg.image_height <= pwdata[SIZE_W-1:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // Shifts read back sign-extended, sizes zero-extended.
    always_comb
    begin
        unique case (reg_index)
            REG_SHIFT_X:      prdata = APB_DATA_W'(cfg_reg.shift_x);
            REG_SHIFT_Y:      prdata = APB_DATA_W'(cfg_reg.shift_y);
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(cfg_reg.image_width);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(cfg_reg.image_height);
            default:          prdata = '0;
        endcase
    end

    // The front shifts and bounds-checks each item; queries that fall outside
    // the image and unused modes never reach the queue.
    pcom_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cmd_valid  (front_valid),
        .cmd_ready  (front_ready),
        .cmd        (front_cmd)
    );

    pcom_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_cmd    (back_cmd)
    );

    // The back executes loads, clears and table scans in order and owns the
    // result register that parts it from the output side.
    pcom_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (back_valid),
        .cmd_ready    (back_ready),
        .cmd          (back_cmd),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/pcom_checker.sv =====
// Port-level checker for the point catalog offset matcher and its bind.
// Depends on pcom_pkg and point_catalog_offset_match_top.
`default_nettype none

module pcom_checker
    import pcom_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         result_valid,
    input logic         result_ready,
    input pcom_result_t result
);

    logic [MATCH_W-1:0] last_num_reg;
    logic               have_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_num_reg  <= '0;
            have_last_reg <= 1'b0;
        end
        else if (result_valid && result_ready)
        begin
            last_num_reg  <= result.match_number;
            have_last_reg <= 1'b1;
        end
    end

    // No result shows on the first edge after reset is released.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !result_valid)
        else $error("result valid right after reset");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("result changed while stalled");

    // Match numbers step by one, restart at zero after a clear, or stick at
    // the saturation value.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && have_last_reg |->
            (result.match_number == last_num_reg + 1'b1) ||
            (result.match_number == '0) ||
            ((last_num_reg == '1) && (result.match_number == '1)))
        else $error("match number out of sequence");

endmodule

bind point_catalog_offset_match_top pcom_checker u_pcom_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire
